/* hw/rtl/cclii_pkg.sv */
// Shared types and constants for the cheat code list interpreter.
// Used by the front classifier, the item queue, the executor and the top level.
`default_nettype none

package cclii_pkg;

	localparam int QUEUE_DEPTH = 4;

	localparam logic [31:0] SEG_CACHED   = 32'h8000_0000;
	localparam logic [31:0] SEG_UNCACHED = 32'hA000_0000;

	// code types (top byte of the command word)
	localparam logic [7:0] TYPE_END    = 8'h00;
	localparam logic [7:0] TYPE_REPEAT = 8'h50;
	localparam logic [7:0] TYPE_WB_C   = 8'h80;
	localparam logic [7:0] TYPE_WH_C   = 8'h81;
	localparam logic [7:0] TYPE_WB_U   = 8'hA0;
	localparam logic [7:0] TYPE_WH_U   = 8'hA1;
	localparam logic [7:0] TYPE_RD_EQB = 8'hD0;
	localparam logic [7:0] TYPE_RD_EQH = 8'hD1;
	localparam logic [7:0] TYPE_RD_NEB = 8'hD2;
	localparam logic [7:0] TYPE_RD_NEH = 8'hD3;

	typedef enum logic [2:0] {
		CLS_RESP,
		CLS_WRITE_C,
		CLS_WRITE_U,
		CLS_REPEAT,
		CLS_READ,
		CLS_END,
		CLS_OTHER
	} cls_t;

	typedef enum logic [1:0] {
		ACC_WB,
		ACC_WH,
		ACC_RB,
		ACC_RH
	} acc_t;

	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_READ,
		MODE_RUN
	} mode_t;

	// one classified word as it sits in the queue
	typedef struct packed {
		cls_t        cls;
		logic [31:0] address;  // segment already applied; low 16 bits hold count/stride for 50
		logic [15:0] value;    // operand for entries, read data for responses
		logic        fresh;
		logic [1:0]  sub;      // type bits 25..24: half select, inequality test
	} item_t;

endpackage

`default_nettype wire

/* hw/rtl/cheat_code_list_interpreter_unit.sv */
// Top level of the cheat code list interpreter: front classifier, item queue, executor.
// Depends on cclii_pkg, cclii_front, cclii_queue and cclii_exec.
`default_nettype none

// Takes code entries and memory responses on the slave stream and issues memory
// transactions on the master stream. Sustained rate is one word per cycle: the
// executor retires one queued word each cycle while its output register is free,
// and a word that causes a transaction is registered in the queue and then in the
// output register before it raises m_tvalid. The QUEUE_DEPTH-entry queue lets the
// input keep taking words while the output side is stalled; the real pace is set
// by how fast memory returns read data and write acknowledges.
module cheat_code_list_interpreter_unit #(
	parameter int QUEUE_DEPTH = cclii_pkg::QUEUE_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [71:0] s_tdata,  // command, operand, new_cheat, read_data, zero pad
	input  wire logic        s_tuser,  // kind
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [47:0]      m_tdata,  // address, data
	output logic [1:0]       m_tuser,  // access
	output logic             m_tlast   // run_last
);

	cclii_pkg::item_t in_item, head_item;
	logic             push, queue_full, queue_valid, pop;

	cclii_front u_front (
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.queue_full (queue_full),
		.push       (push),
		.item       (in_item)
	);

	cclii_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (in_item),
		.full      (queue_full),
		.pop       (pop),
		.valid     (queue_valid),
		.head      (head_item)
	);

	cclii_exec u_exec (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (queue_valid),
		.item       (head_item),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast)
	);

endmodule

`default_nettype wire

/* hw/rtl/cclii_front.sv */
// Input side: takes stream words, classifies the code type and forms the queue item.
// Depends on cclii_pkg.
`default_nettype none

module cclii_front (
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	input  wire logic [71:0]        s_tdata,  // command, operand, new_cheat, read_data, zero pad
	input  wire logic               s_tuser,  // kind
	input  wire logic               queue_full,
	output logic                    push,
	output cclii_pkg::item_t        item
);

	logic [7:0]  code_type;
	logic [31:0] low24;
	cclii_pkg::cls_t cls;

	assign code_type = s_tdata[31:24];
	assign low24     = {8'h00, s_tdata[23:0]};

	always_comb begin
		unique case (code_type) inside
			cclii_pkg::TYPE_REPEAT: cls = cclii_pkg::CLS_REPEAT;
			cclii_pkg::TYPE_WB_C, cclii_pkg::TYPE_WH_C: cls = cclii_pkg::CLS_WRITE_C;
			cclii_pkg::TYPE_WB_U, cclii_pkg::TYPE_WH_U: cls = cclii_pkg::CLS_WRITE_U;
			cclii_pkg::TYPE_RD_EQB, cclii_pkg::TYPE_RD_EQH,
			cclii_pkg::TYPE_RD_NEB, cclii_pkg::TYPE_RD_NEH: cls = cclii_pkg::CLS_READ;
			cclii_pkg::TYPE_END: cls = cclii_pkg::CLS_END;
			default: cls = cclii_pkg::CLS_OTHER;
		endcase
	end

	always_comb begin
		item.cls     = s_tuser ? cclii_pkg::CLS_RESP : cls;
		item.address = ((cls == cclii_pkg::CLS_WRITE_U) ? cclii_pkg::SEG_UNCACHED
			: cclii_pkg::SEG_CACHED) | low24;
		item.value   = s_tuser ? s_tdata[64:49] : s_tdata[47:32];
		item.fresh   = s_tdata[48];
		item.sub     = code_type[1:0];
	end

	assign s_tready = !queue_full;
	assign push     = s_tvalid && !queue_full;

endmodule

`default_nettype wire

/* hw/rtl/cclii_queue.sv */
// Short FIFO of classified items between the front and the executor.
// Depends on cclii_pkg.
`default_nettype none

module cclii_queue #(
	parameter int DEPTH = cclii_pkg::QUEUE_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire cclii_pkg::item_t push_item,
	output logic                  full,
	input  wire logic             pop,
	output logic                  valid,
	output cclii_pkg::item_t      head
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cclii_pkg::item_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign valid   = (count_q != '0);
	assign do_push = push && !full;
	assign do_pop  = pop && valid;
	assign head    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/cclii_exec.sv */
// Back end: holds the interpreter state, carries out one queued item per cycle while
// the output register is free, and drives that register. Depends on cclii_pkg.
`default_nettype none

module cclii_exec (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             item_valid,
	input  wire cclii_pkg::item_t item,
	output logic                  pop,
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	output logic [47:0]           m_tdata,  // address, data
	output logic [1:0]            m_tuser,  // access
	output logic                  m_tlast   // run_last
);

	// interpreter state
	logic            exec_flag_q, repeat_armed_q, cheat_done_q;
	logic [7:0]      repeat_count_q, repeat_stride_q, runs_left_q;
	logic [15:0]     repeat_step_q, run_data_q, compare_value_q;
	logic [31:0]     run_address_q;
	logic            run_is_half_q;
	logic [1:0]      compare_type_q;
	cclii_pkg::mode_t mode_q, mode_d;

	// output register
	logic            out_valid_q, out_last_q;
	cclii_pkg::acc_t out_acc_q;
	logic [31:0]     out_address_q;
	logic [15:0]     out_data_q;

	// effective state after a new_cheat clear
	logic            is_resp, is_entry, fresh_clr;
	logic            flag_e, armed_e, done_e;
	logic [7:0]      runs_e;
	cclii_pkg::mode_t mode_e;

	logic            entry_go, armed_write, start_run, plain;
	logic            resp_read, resp_run, emit_run, emit_single, emit_read, emit;
	logic            mismatch;
	logic [15:0]     mem_value;

	logic [7:0]      run_cnt_cur;
	logic [31:0]     run_addr_cur;
	logic [15:0]     run_data_cur;
	logic            run_half_cur;

	cclii_pkg::acc_t emit_acc;
	logic [31:0]     emit_address;
	logic [15:0]     emit_data;
	logic            emit_last;

	assign pop = item_valid && (!out_valid_q || m_tready);

	assign is_resp   = (item.cls == cclii_pkg::CLS_RESP);
	assign is_entry  = !is_resp;
	assign fresh_clr = is_entry && item.fresh;

	assign flag_e  = fresh_clr ? 1'b1 : exec_flag_q;
	assign armed_e = fresh_clr ? 1'b0 : repeat_armed_q;
	assign done_e  = fresh_clr ? 1'b0 : cheat_done_q;
	assign runs_e  = fresh_clr ? 8'd0 : runs_left_q;
	assign mode_e  = fresh_clr ? cclii_pkg::MODE_IDLE : mode_q;

	assign entry_go    = is_entry && !done_e && (mode_e == cclii_pkg::MODE_IDLE);
	assign armed_write = entry_go && armed_e && (item.cls == cclii_pkg::CLS_WRITE_C);
	assign start_run   = armed_write && (repeat_count_q != 8'd0);
	assign plain       = entry_go && !armed_write;
	assign resp_read   = is_resp && (mode_q == cclii_pkg::MODE_READ);
	assign resp_run    = is_resp && (mode_q == cclii_pkg::MODE_RUN) && (runs_left_q != 8'd0);
	assign emit_run    = start_run || resp_run;
	assign emit_single = plain && flag_e
		&& ((item.cls == cclii_pkg::CLS_WRITE_C) || (item.cls == cclii_pkg::CLS_WRITE_U));
	assign emit_read   = plain && (item.cls == cclii_pkg::CLS_READ);
	assign emit        = emit_run || emit_single || emit_read;

	// byte compares use the low byte of the read data against the full operand
	assign mem_value = compare_type_q[0] ? item.value : {8'h00, item.value[7:0]};
	assign mismatch  = (mem_value == compare_value_q) == compare_type_q[1];

	// a starting run takes its first write straight from the entry
	assign run_cnt_cur  = start_run ? repeat_count_q : runs_left_q;
	assign run_addr_cur = start_run ? item.address : run_address_q;
	assign run_data_cur = start_run ? item.value : run_data_q;
	assign run_half_cur = start_run ? item.sub[0] : run_is_half_q;

	// next mode
	always_comb begin
		mode_d = mode_e;
		if (emit_run) begin
			mode_d = (run_cnt_cur == 8'd1) ? cclii_pkg::MODE_IDLE : cclii_pkg::MODE_RUN;
		end else if (resp_read) begin
			mode_d = cclii_pkg::MODE_IDLE;
		end else if (emit_read) begin
			mode_d = cclii_pkg::MODE_READ;
		end
	end

	// transaction to emit
	always_comb begin
		emit_acc     = cclii_pkg::ACC_WB;
		emit_address = item.address;
		emit_data    = item.value;
		emit_last    = 1'b1;
		if (emit_run) begin
			emit_acc     = run_half_cur ? cclii_pkg::ACC_WH : cclii_pkg::ACC_WB;
			emit_address = run_addr_cur;
			emit_data    = run_data_cur;
			emit_last    = (run_cnt_cur == 8'd1);
		end else if (emit_read) begin
			emit_acc  = item.sub[0] ? cclii_pkg::ACC_RH : cclii_pkg::ACC_RB;
			emit_data = 16'h0000;
			emit_last = 1'b0;
		end else begin
			emit_acc = item.sub[0] ? cclii_pkg::ACC_WH : cclii_pkg::ACC_WB;
		end
		if (emit_acc == cclii_pkg::ACC_WB) begin
			emit_data = {8'h00, emit_data[7:0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exec_flag_q     <= 1'b1;
			repeat_armed_q  <= 1'b0;
			cheat_done_q    <= 1'b0;
			repeat_count_q  <= '0;
			repeat_stride_q <= '0;
			repeat_step_q   <= '0;
			runs_left_q     <= '0;
			run_address_q   <= '0;
			run_data_q      <= '0;
			run_is_half_q   <= 1'b0;
			compare_value_q <= '0;
			compare_type_q  <= '0;
			mode_q          <= cclii_pkg::MODE_IDLE;
		end else if (pop) begin
			mode_q       <= mode_d;
			cheat_done_q <= done_e || (plain && (item.cls == cclii_pkg::CLS_END));
			repeat_armed_q <= entry_go ? (plain && (item.cls == cclii_pkg::CLS_REPEAT))
				: armed_e;

			if (resp_read) begin
				exec_flag_q <= mismatch ? 1'b0 : exec_flag_q;
			end else if (entry_go) begin
				exec_flag_q <= (plain && (item.cls == cclii_pkg::CLS_READ)) ? flag_e : 1'b1;
			end else begin
				exec_flag_q <= flag_e;
			end

			if (plain && (item.cls == cclii_pkg::CLS_REPEAT)) begin
				repeat_count_q  <= item.address[15:8];
				repeat_stride_q <= item.address[7:0];
				repeat_step_q   <= item.value;
			end

			if (emit_run) begin
				runs_left_q   <= run_cnt_cur - 8'd1;
				run_address_q <= run_addr_cur + {24'h000000, repeat_stride_q};
				run_data_q    <= run_data_cur + repeat_step_q;
				run_is_half_q <= run_half_cur;
			end else begin
				runs_left_q <= runs_e;
			end

			if (emit_read) begin
				compare_value_q <= item.value;
				compare_type_q  <= item.sub;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || m_tready) begin
			out_valid_q <= pop && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emit) begin
			out_acc_q     <= emit_acc;
			out_address_q <= emit_address;
			out_data_q    <= emit_data;
			out_last_q    <= emit_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_data_q, out_address_q};
	assign m_tuser  = out_acc_q;
	assign m_tlast  = out_last_q;

endmodule

`default_nettype wire
